/* sv/srt_pkg.sv */
package srt_pkg;

    localparam int SRT_MAX_SECTORS = 64;
    localparam int BOX_STRIDE      = 6;
    localparam int COORD_W         = 24;
    localparam int RADIUS_W        = 20;
    localparam int GROW_W          = 21;
    localparam int WIDE_W          = 26;
    localparam int DIST_W          = 25;
    localparam int SQ_W            = 2 * DIST_W;
    localparam int D2_W            = SQ_W + 2;
    localparam int SECT_FIELD_W    = 6;
    localparam int COUNT_FIELD_W   = 7;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;

    // z slack for clutter, Q20.4: 100.0 and 110.0 world units
    localparam logic [GROW_W-1:0] CLUTTER_SLACK_R = GROW_W'(1600);
    localparam logic [GROW_W-1:0] CLUTTER_SLACK_0 = GROW_W'(1760);

    // bound positions within a box row
    localparam logic [2:0] CRD_MINX = 3'd0;
    localparam logic [2:0] CRD_MINY = 3'd1;
    localparam logic [2:0] CRD_MINZ = 3'd2;
    localparam logic [2:0] CRD_MAXX = 3'd3;
    localparam logic [2:0] CRD_MAXY = 3'd4;
    localparam logic [2:0] CRD_MAXZ = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VISIBLE_MASK = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_XY_PADDING   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_PADDING    = 3'd4;

    // decision codes
    localparam logic [2:0] DEC_DISABLED = 3'd0;
    localparam logic [2:0] DEC_VISIBLE  = 3'd1;
    localparam logic [2:0] DEC_HIDDEN   = 3'd2;
    localparam logic [2:0] DEC_NEAREST  = 3'd3;
    localparam logic [2:0] DEC_NONE     = 3'd4;

    typedef logic [BOX_STRIDE-1:0][COORD_W-1:0] box_row_t;

    // query terms precomputed at accept time
    typedef struct packed {
        logic signed [WIDE_W-1:0] x_hi;
        logic signed [WIDE_W-1:0] x_lo;
        logic signed [WIDE_W-1:0] y_hi;
        logic signed [WIDE_W-1:0] y_lo;
        logic signed [WIDE_W-1:0] z_hi;
        logic signed [WIDE_W-1:0] z_lo;
        logic signed [WIDE_W-1:0] ox;
        logic signed [WIDE_W-1:0] oy;
        logic signed [WIDE_W-1:0] dz_hi;
        logic signed [WIDE_W-1:0] dz_lo;
    } srt_query_t;

    typedef struct packed {
        logic                    valid;
        logic                    busy;
        logic                    overlap;
        logic [SECT_FIELD_W-1:0] idx;
        logic [D2_W-1:0]         d2;
    } srt_hit_t;

endpackage

/* sv/srt_box_eval.sv */
module srt_box_eval
    import srt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  srt_query_t              query,
    input  logic                    in_valid,
    input  box_row_t                in_row,
    input  logic [SECT_FIELD_W-1:0] in_idx,
    output srt_hit_t                hit
);

    logic signed [WIDE_W-1:0] mnx, mny, mnz, mxx, mxy, mxz;
    logic                     ov_now;
    logic [DIST_W-1:0]        dx_now, dy_now, dz_now;

    logic                    valid_b_reg, valid_c_reg, valid_d_reg;
    logic                    ov_b_reg, ov_c_reg, ov_d_reg;
    logic [SECT_FIELD_W-1:0] idx_b_reg, idx_c_reg, idx_d_reg;
    logic [DIST_W-1:0]       dx_b_reg, dy_b_reg, dz_b_reg;
    logic [SQ_W-1:0]         sqx_c_reg, sqy_c_reg, sqz_c_reg;
    logic [D2_W-1:0]         d2_d_reg;

    function automatic logic [DIST_W-1:0] span_dist(
        input logic signed [WIDE_W-1:0] p_lo,
        input logic signed [WIDE_W-1:0] p_hi,
        input logic signed [WIDE_W-1:0] lo,
        input logic signed [WIDE_W-1:0] hi
    );
        logic signed [WIDE_W-1:0] diff;
        diff = '0;
        if (p_lo < lo) begin
            diff = lo - p_lo;
        end else if (p_hi > hi) begin
            diff = p_hi - hi;
        end
        return diff[DIST_W-1:0];
    endfunction

    assign mnx = WIDE_W'($signed(in_row[CRD_MINX]));
    assign mny = WIDE_W'($signed(in_row[CRD_MINY]));
    assign mnz = WIDE_W'($signed(in_row[CRD_MINZ]));
    assign mxx = WIDE_W'($signed(in_row[CRD_MAXX]));
    assign mxy = WIDE_W'($signed(in_row[CRD_MAXY]));
    assign mxz = WIDE_W'($signed(in_row[CRD_MAXZ]));

    assign ov_now = (query.x_hi >= mnx) && (query.x_lo <= mxx)
                 && (query.y_hi >= mny) && (query.y_lo <= mxy)
                 && (query.z_hi >= mnz) && (query.z_lo <= mxz);

    // z distance is to the slack-grown range: lo test uses oz+slack, hi uses oz-slack
    assign dx_now = span_dist(query.ox, query.ox, mnx, mxx);
    assign dy_now = span_dist(query.oy, query.oy, mny, mxy);
    assign dz_now = span_dist(query.dz_hi, query.dz_lo, mnz, mxz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            valid_b_reg <= in_valid;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
        ov_b_reg  <= ov_now;
        idx_b_reg <= in_idx;
        dx_b_reg  <= dx_now;
        dy_b_reg  <= dy_now;
        dz_b_reg  <= dz_now;

        ov_c_reg  <= ov_b_reg;
        idx_c_reg <= idx_b_reg;
        sqx_c_reg <= dx_b_reg * dx_b_reg;
        sqy_c_reg <= dy_b_reg * dy_b_reg;
        sqz_c_reg <= dz_b_reg * dz_b_reg;

        ov_d_reg  <= ov_c_reg;
        idx_d_reg <= idx_c_reg;
        d2_d_reg  <= D2_W'(sqx_c_reg) + D2_W'(sqy_c_reg) + D2_W'(sqz_c_reg);
    end

    assign hit.valid   = valid_d_reg;
    assign hit.busy    = valid_b_reg | valid_c_reg | valid_d_reg;
    assign hit.overlap = ov_d_reg;
    assign hit.idx     = idx_d_reg;
    assign hit.d2      = d2_d_reg;

endmodule

/* sv/sector_residency_test_unit.sv */
// Sector residency test unit.
// Input channel (s_*): kind 0 loads one bound of one sector box into the box
// memory and gives no result; kind 1 is a residency query giving one result
// on the m_* channel (resident, decision, deciding_sector).
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data), to be
// used only while the unit is idle; the unit itself does not enforce this.
// A query walks sectors 0..sector_count-1, reading one box row per cycle from
// the box memory, through a four-stage pipeline (memory read, compares, squares,
// sum). A visible overlap ends the walk early; a disabled query skips the walk
// and goes straight to its result. The single memory read port sets the walk
// rate of one sector per cycle; one query is in flight at a time.
// The result sits in an output register; s_ready stays high for new requests
// while it waits, and a following query holds at its end until the register
// is free. Reset clears the configuration and control registers; the box memory
// is not cleared and every bound read by a query must have been loaded first.
module sector_residency_test_unit
    import srt_pkg::*;
#(
    parameter int MAX_SECTORS = SRT_MAX_SECTORS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [SECT_FIELD_W-1:0]  s_sector,
    input  logic [2:0]               s_coord,
    input  logic signed [COORD_W-1:0] s_value,
    input  logic signed [COORD_W-1:0] s_origin_x,
    input  logic signed [COORD_W-1:0] s_origin_y,
    input  logic signed [COORD_W-1:0] s_origin_z,
    input  logic [RADIUS_W-1:0]      s_radius,
    input  logic                     s_structural,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_resident,
    output logic [2:0]               m_decision,
    output logic [SECT_FIELD_W-1:0]  m_deciding_sector
);

    localparam int SECT_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CNT_W  = $clog2(MAX_SECTORS + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

    state_t state_reg;

    logic                       enable_reg;
    logic [COUNT_FIELD_W-1:0]   sector_count_reg;
    logic [CFG_DATA_W-1:0]      visible_mask_reg;
    logic [RADIUS_W-1:0]        xy_padding_reg;
    logic [RADIUS_W-1:0]        z_padding_reg;

    box_row_t                   box_mem [MAX_SECTORS];
    box_row_t                   row_reg;
    logic                       rd_valid_reg;
    logic [SECT_FIELD_W-1:0]    rd_idx6_reg;
    logic [CNT_W-1:0]           rd_idx_reg;

    srt_query_t                 query_reg;
    logic                       structural_reg;
    srt_hit_t                   hit;

    logic                       touched_reg, have_near_reg, done_reg;
    logic [SECT_FIELD_W-1:0]    first_reg, near_reg, deciding_reg;
    logic [D2_W-1:0]            near_d2_reg;

    logic                       res_resident_reg;
    logic [2:0]                 res_decision_reg;
    logic [SECT_FIELD_W-1:0]    res_sector_reg;

    logic                       m_valid_reg;
    logic                       m_resident_reg;
    logic [2:0]                 m_decision_reg;
    logic [SECT_FIELD_W-1:0]    m_deciding_sector_reg;

    logic                       accept, load_wr, issue, walk_end, active;
    logic [SECT_W-1:0]          rd_addr;
    logic [GROW_W-1:0]          slack, g_xy, g_z;
    logic signed [WIDE_W-1:0]   ox_w, oy_w, oz_w;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign load_wr = accept && !s_kind && (s_coord < 3'(BOX_STRIDE))
                  && ({1'b0, s_sector} < COUNT_FIELD_W'(MAX_SECTORS));

    assign active  = enable_reg && (sector_count_reg != '0)
                  && (sector_count_reg <= COUNT_FIELD_W'(MAX_SECTORS))
                  && (visible_mask_reg != '0);

    assign rd_addr  = rd_idx_reg[SECT_W-1:0];
    assign issue    = (state_reg == S_WALK) && !done_reg
                   && (COUNT_FIELD_W'(rd_idx_reg) < sector_count_reg);
    assign walk_end = (state_reg == S_WALK) && !rd_valid_reg && !hit.busy
                   && (done_reg || (COUNT_FIELD_W'(rd_idx_reg) >= sector_count_reg));

    // query terms, formed once per request
    assign slack = (s_radius != '0) ? CLUTTER_SLACK_R : CLUTTER_SLACK_0;
    assign g_xy  = s_structural ? (GROW_W'(s_radius) + GROW_W'(xy_padding_reg))
                                : GROW_W'(s_radius);
    assign g_z   = s_structural ? (GROW_W'(s_radius) + GROW_W'(z_padding_reg)) : slack;
    assign ox_w  = WIDE_W'(s_origin_x);
    assign oy_w  = WIDE_W'(s_origin_y);
    assign oz_w  = WIDE_W'(s_origin_z);

    // loads are taken only when idle and reads happen only while walking,
    // so a write never meets a read of the same row
    always_ff @(posedge aclk) begin
        if (load_wr) begin
            box_mem[s_sector[SECT_W-1:0]][s_coord] <= s_value;
        end
        if (issue) begin
            row_reg <= box_mem[rd_addr];
        end
        rd_idx6_reg <= SECT_FIELD_W'(rd_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            sector_count_reg <= '0;
            visible_mask_reg <= '0;
            xy_padding_reg   <= '0;
            z_padding_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENABLE:       enable_reg       <= cfg_data[0];
                REG_SECTOR_COUNT: sector_count_reg <= cfg_data[COUNT_FIELD_W-1:0];
                REG_VISIBLE_MASK: visible_mask_reg <= cfg_data;
                REG_XY_PADDING:   xy_padding_reg   <= cfg_data[RADIUS_W-1:0];
                REG_Z_PADDING:    z_padding_reg    <= cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    srt_box_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .query    (query_reg),
        .in_valid (rd_valid_reg),
        .in_row   (row_reg),
        .in_idx   (rd_idx6_reg),
        .hit      (hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            touched_reg   <= 1'b0;
            have_near_reg <= 1'b0;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            // in S_DONE the output register is handled below
            if (m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept && s_kind) begin
                        query_reg.x_hi  <= ox_w + WIDE_W'(g_xy);
                        query_reg.x_lo  <= ox_w - WIDE_W'(g_xy);
                        query_reg.y_hi  <= oy_w + WIDE_W'(g_xy);
                        query_reg.y_lo  <= oy_w - WIDE_W'(g_xy);
                        query_reg.z_hi  <= oz_w + WIDE_W'(g_z);
                        query_reg.z_lo  <= oz_w - WIDE_W'(g_z);
                        query_reg.ox    <= ox_w;
                        query_reg.oy    <= oy_w;
                        query_reg.dz_hi <= oz_w + WIDE_W'(slack);
                        query_reg.dz_lo <= oz_w - WIDE_W'(slack);
                        structural_reg  <= s_structural;
                        rd_idx_reg      <= '0;
                        touched_reg     <= 1'b0;
                        have_near_reg   <= 1'b0;
                        done_reg        <= 1'b0;
                        if (active) begin
                            state_reg <= S_WALK;
                        end else begin
                            res_resident_reg <= 1'b1;
                            res_decision_reg <= DEC_DISABLED;
                            res_sector_reg   <= '0;
                            state_reg        <= S_DONE;
                        end
                    end
                end
                S_WALK: begin
                    if (hit.valid && !done_reg) begin
                        if (!structural_reg && (!have_near_reg || hit.d2 < near_d2_reg)) begin
                            have_near_reg <= 1'b1;
                            near_d2_reg   <= hit.d2;
                            near_reg      <= hit.idx;
                        end
                        if (hit.overlap) begin
                            if (!touched_reg) begin
                                touched_reg <= 1'b1;
                                first_reg   <= hit.idx;
                            end
                            if (visible_mask_reg[hit.idx]) begin
                                done_reg     <= 1'b1;
                                deciding_reg <= hit.idx;
                            end
                        end
                    end
                    if (walk_end) begin
                        state_reg <= S_DONE;
                        if (done_reg) begin
                            res_resident_reg <= 1'b1;
                            res_decision_reg <= DEC_VISIBLE;
                            res_sector_reg   <= deciding_reg;
                        end else if (touched_reg) begin
                            res_resident_reg <= 1'b0;
                            res_decision_reg <= DEC_HIDDEN;
                            res_sector_reg   <= first_reg;
                        end else if (!structural_reg && have_near_reg) begin
                            res_resident_reg <= visible_mask_reg[near_reg];
                            res_decision_reg <= DEC_NEAREST;
                            res_sector_reg   <= near_reg;
                        end else begin
                            res_resident_reg <= 1'b1;
                            res_decision_reg <= DEC_NONE;
                            res_sector_reg   <= '0;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_resident_reg        <= res_resident_reg;
                        m_decision_reg        <= res_decision_reg;
                        m_deciding_sector_reg <= res_sector_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_resident        = m_resident_reg;
    assign m_decision        = m_decision_reg;
    assign m_deciding_sector = m_deciding_sector_reg;

`ifndef NO_ASSERTIONS
    a_hit_only_walking: assert property (@(posedge aclk) disable iff (!aresetn)
        hit.busy |-> (state_reg == S_WALK))
        else $error("evaluator busy outside a walk");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (COUNT_FIELD_W'(rd_idx_reg) <= sector_count_reg))
        else $error("read index passed sector count");

    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (COUNT_FIELD_W'(m_deciding_sector_reg) < COUNT_FIELD_W'(MAX_SECTORS)))
        else $error("deciding sector out of range");

    a_hidden_not_resident: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_decision_reg == DEC_HIDDEN)) |-> !m_resident_reg)
        else $error("hidden decision marked resident");

    a_keep_resident: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ((m_decision_reg == DEC_DISABLED) || (m_decision_reg == DEC_VISIBLE)
            || (m_decision_reg == DEC_NONE))) |-> m_resident_reg)
        else $error("resident flag disagrees with decision");
`endif

endmodule
